// ===== hdl/tsrt_pkg.sv =====
`default_nettype none
package tsrt_pkg;

   // field widths of a transaction
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned TAG_W    = 32;
   localparam int unsigned POS_W    = 6;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned AT_W     = 6;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned ENTRY_W  = TIME_W + TAG_W;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SCAN,
      S_INS_HEAD,
      S_DEL_MOVE,
      S_DONE
   } tsrt_state_type;

endpackage
`default_nettype wire

// ===== hdl/time_sorted_record_table_core.sv =====
`default_nettype none
// time-sorted record table: up to TABLE_DEPTH (time_stamp, record_tag) pairs held in one
// synchronous entry memory in descending time order, newest first. an insert transaction
// (req_tuser = 0) places its pair in front of the first entry whose time is not greater,
// so equal times keep the latest arrival first; a delete (req_tuser = 1) removes the entry
// at the given position and closes the gap. every request gives exactly one response with
// status (0 done, 1 table full, 2 position out of range), the index acted on and the entry
// count afterwards; placed_at and entry_count wrap at 64 and 128 for deeper tables.
// one request is in work at a time. the memory has one read and one write port and moves
// one entry per cycle: an insert scans from the tail towards the head, shifting each entry
// one place back until a newer one is found, and a delete pulls each later entry up one
// place, so the work grows with the distance of the position from the tail.
// a new request is taken while the previous response still waits on rsp_tready.
module time_sorted_record_table_core #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // time_stamp [31:0], record_tag [63:32], position [69:64], zero [71:70]
   input  wire  [71:0] req_tdata,
   // operation [0]
   input  wire  [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // status [1:0], placed_at [7:2], entry_count [14:8], zero [15]
   output logic [15:0] rsp_tdata
);
   import tsrt_pkg::*;

   localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

   // request fields
   logic [TIME_W-1:0] req_time;
   logic [TAG_W-1:0]  req_tag;
   logic [POS_W-1:0]  req_pos;
   logic              req_op;

   assign req_time = req_tdata[TIME_W-1:0];
   assign req_tag  = req_tdata[TIME_W+TAG_W-1:TIME_W];
   assign req_pos  = req_tdata[TIME_W+TAG_W+POS_W-1:TIME_W+TAG_W];
   assign req_op   = req_tuser[0];

   // entry memory: time in the upper half, tag in the lower half
   logic [ENTRY_W-1:0] entry_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] mem_rd_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= entry_mem[rd_addr];
   end

   // control and working registers
   tsrt_state_type      state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [AW-1:0]       res_at_ff, res_at_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [AT_W-1:0]     rsp_at_ff, rsp_at_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      time_ff       <= time_in;
      tag_ff        <= tag_in;
      res_status_ff <= res_status_in;
      res_at_ff     <= res_at_in;
      rsp_status_ff <= rsp_status_in;
      rsp_at_ff     <= rsp_at_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // widened views for compares and address arithmetic
   logic [CMPW-1:0]    pos_w;
   logic [CMPW-1:0]    cnt_w;
   logic [CW-1:0]      idx_w;
   logic [ENTRY_W-1:0] held_entry;

   assign pos_w      = CMPW'(req_pos);
   assign cnt_w      = CMPW'(count_ff);
   assign idx_w      = CW'(idx_ff);
   assign held_entry = {time_ff, tag_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      time_in       = time_ff;
      tag_in        = tag_ff;
      res_status_in = res_status_ff;
      res_at_in     = res_at_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_at_in     = rsp_at_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = held_entry;
      rd_addr       = idx_ff;
      // nothing is taken while reset is held
      req_tready    = (state_ff == S_IDLE) && !reset;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               time_in = req_time;
               tag_in  = req_tag;
               if (req_op == OP_INSERT) begin
                  if (count_ff == CW'(TABLE_DEPTH)) begin
                     res_status_in = ST_FULL;
                     res_at_in     = '0;
                     state_in      = S_DONE;
                  end else if (count_ff == '0) begin
                     // empty table: the new entry goes straight to the head
                     wr_en         = 1'b1;
                     wr_addr       = '0;
                     wr_data       = {req_time, req_tag};
                     count_in      = count_ff + CW'(1);
                     res_status_in = ST_DONE;
                     res_at_in     = '0;
                     state_in      = S_DONE;
                  end else begin
                     // scan from the tail towards the head
                     rd_addr  = AW'(count_ff - CW'(1));
                     idx_in   = AW'(count_ff - CW'(1));
                     state_in = S_INS_SCAN;
                  end
               end else begin
                  if (pos_w >= cnt_w) begin
                     res_status_in = ST_RANGE;
                     res_at_in     = '0;
                     state_in      = S_DONE;
                  end else if (pos_w == cnt_w - CMPW'(1)) begin
                     // last entry: nothing to move up
                     count_in      = count_ff - CW'(1);
                     res_status_in = ST_DONE;
                     res_at_in     = AW'(req_pos);
                     state_in      = S_DONE;
                  end else begin
                     rd_addr       = AW'(pos_w + CMPW'(1));
                     idx_in        = AW'(req_pos);
                     res_status_in = ST_DONE;
                     res_at_in     = AW'(req_pos);
                     state_in      = S_DEL_MOVE;
                  end
               end
            end
         end

         S_INS_SCAN: begin
            // mem_rd_ff holds entry idx_ff
            wr_en   = 1'b1;
            wr_addr = AW'(idx_w + CW'(1));
            if (mem_rd_ff[ENTRY_W-1:TAG_W] > time_ff) begin
               // newer entry found: new record lands just behind it
               wr_data       = held_entry;
               count_in      = count_ff + CW'(1);
               res_status_in = ST_DONE;
               res_at_in     = AW'(idx_w + CW'(1));
               state_in      = S_DONE;
            end else begin
               wr_data = mem_rd_ff;
               if (idx_ff == '0) begin
                  state_in = S_INS_HEAD;
               end else begin
                  rd_addr = idx_ff - AW'(1);
                  idx_in  = idx_ff - AW'(1);
               end
            end
         end

         S_INS_HEAD: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = held_entry;
            count_in      = count_ff + CW'(1);
            res_status_in = ST_DONE;
            res_at_in     = '0;
            state_in      = S_DONE;
         end

         S_DEL_MOVE: begin
            // mem_rd_ff holds entry idx_ff + 1, moved up one place
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = mem_rd_ff;
            if (idx_w + CW'(2) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               rd_addr = AW'(idx_w + CW'(2));
               idx_in  = AW'(idx_w + CW'(1));
            end
         end

         S_DONE: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_at_in     = AT_W'(res_at_ff);
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_at_ff, rsp_status_ff};

   // the table never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // memory writes stay within the valid entries plus the one being added
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CW'(wr_addr) <= count_ff)
      else $error("entry write beyond the table fill");

   // a delete move always has a later valid entry to pull up
   a_del_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL_MOVE) |-> (idx_w + CW'(1) < count_ff))
      else $error("delete move past the last entry");

   // a finished response is never overwritten while it waits
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_tdata)))
      else $error("pending response lost");

endmodule
`default_nettype wire

// ===== tb/time_sorted_record_table_core_tb.sv =====
`timescale 1ns / 1ps
module time_sorted_record_table_core_tb;
   import tsrt_pkg::*;

   localparam int DEPTH        = 64;
   localparam int HOLD_CYCLES  = 400;      // long receiver hold-off, in cycles
   localparam int SETTLE       = 80;       // idle wait before the final report
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1050;

   typedef enum logic {PACE_STEADY, PACE_JITTER} pace_type;

   // one response as it appears on rsp_tdata[14:0]
   typedef struct packed {
      logic [COUNT_W-1:0]  entry_count;
      logic [AT_W-1:0]     placed_at;
      logic [STATUS_W-1:0] status;
   } table_outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [71:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;

   // predicted table contents, newest first
   logic [TIME_W-1:0] table_time [DEPTH];
   logic [TAG_W-1:0]  table_tag  [DEPTH];
   int                table_fill = 0;

   table_outcome_type pending_outcomes[$];

   int unsigned error_count    = 0;
   int unsigned items_sent     = 0;
   int unsigned outcomes_seen  = 0;
   int unsigned inserts_placed = 0;
   int unsigned deletes_done   = 0;
   int unsigned full_refusals  = 0;
   int unsigned range_refusals = 0;
   int unsigned cycle_count    = 0;

   // pacing of both sides; sink_pace and hold_asked are written with nba only
   pace_type sender_pace = PACE_STEADY;
   pace_type sink_pace   = PACE_STEADY;
   int       hold_asked  = 0;
   int       hold_taken  = 0;
   int       hold_left   = 0;
   int       stall_left  = 0;

   time_sorted_record_table_core #(.TABLE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_outcomes.size());
         $display("FAIL time_sorted_record_table_core");
         $finish;
      end
   end

   // idle cycles between transactions: none when steady; when jittered mostly none or short, now and then long
   function automatic int pick_gap(pace_type pace);
      int roll;
      if (pace == PACE_STEADY)
         return 0;
      roll = $urandom_range(99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // ordering keys: wide random, a narrow window for near misses and ties,
   // copies of stored times for exact ties, and the two extremes
   function automatic logic [TIME_W-1:0] pick_stamp();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40)
         return $urandom;
      if (roll < 70)
         return 32'h4000_0000 + $urandom_range(15);
      if (roll < 90 && table_fill != 0)
         return table_time[$urandom_range(table_fill - 1)];
      if (roll < 95)
         return '0;
      return '1;
   endfunction

   // sorted table behaviour: insert in front of the first entry whose time is
   // not greater, delete closes the gap, refusals leave everything unchanged
   function automatic table_outcome_type predict_table_op(logic op,
                                                          logic [TIME_W-1:0] stamp,
                                                          logic [TAG_W-1:0] tag,
                                                          logic [POS_W-1:0] pos);
      table_outcome_type outcome;
      int slot;
      int i;
      outcome = '0;
      if (op == OP_INSERT) begin
         if (table_fill >= DEPTH) begin
            outcome.status = ST_FULL;
            full_refusals++;
         end else begin
            slot = table_fill;
            for (i = 0; i < table_fill; i++) begin
               if (table_time[i] <= stamp) begin
                  slot = i;
                  break;
               end
            end
            for (i = table_fill; i > slot; i--) begin
               table_time[i] = table_time[i - 1];
               table_tag[i]  = table_tag[i - 1];
            end
            table_time[slot] = stamp;
            table_tag[slot]  = tag;
            table_fill++;
            outcome.status    = ST_DONE;
            outcome.placed_at = slot[AT_W-1:0];
            inserts_placed++;
         end
      end else begin
         if (int'(pos) >= table_fill) begin
            outcome.status = ST_RANGE;
            range_refusals++;
         end else begin
            for (i = int'(pos); i + 1 < table_fill; i++) begin
               table_time[i] = table_time[i + 1];
               table_tag[i]  = table_tag[i + 1];
            end
            table_fill--;
            outcome.status    = ST_DONE;
            outcome.placed_at = pos;
            deletes_done++;
         end
      end
      outcome.entry_count = table_fill[COUNT_W-1:0];
      return outcome;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      error_count++;
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, field, got, want);
   endtask

   // offer one transaction, wait for acceptance, then log what it must return;
   // called and returning on a rising edge
   task automatic send_op(input logic op, input logic [TIME_W-1:0] stamp,
                          input logic [TAG_W-1:0] tag, input logic [POS_W-1:0] pos);
      int gap;
      gap = pick_gap(sender_pace);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, pos, tag, stamp};
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(predict_table_op(op, stamp, tag, pos));
      items_sent++;
   endtask

   // stop offering and wait until every response is back
   task automatic pause_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off whenever the stimulus asks
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = pick_gap(sink_pace);
         rsp_tready <= (stall_left == 0);
      end
   end

   // response checker: each accepted response against the oldest prediction
   always @(posedge clock) begin
      table_outcome_type got;
      table_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = table_outcome_type'(rsp_tdata[14:0]);
         outcomes_seen++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected response, status", got.status, -1);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.status != want.status)
               report_mismatch("status", got.status, want.status);
            if (got.placed_at != want.placed_at)
               report_mismatch("placed_at", got.placed_at, want.placed_at);
            if (got.entry_count != want.entry_count)
               report_mismatch("entry_count", got.entry_count, want.entry_count);
         end
      end
   end

   // corners from an empty table: refused deletes, both time extremes, ties at
   // head and tail, deletes at first, last, middle and out of range
   task automatic test_directed();
      sender_pace = PACE_JITTER;
      sink_pace   <= PACE_JITTER;
      send_op(OP_DELETE, '0, '0, 6'd0);                     // empty table
      send_op(OP_DELETE, '1, '1, 6'd63);
      send_op(OP_INSERT, '0, '0, 6'd63);                    // position ignored
      send_op(OP_INSERT, '1, '1, 6'd0);                     // newest goes first
      send_op(OP_INSERT, '0, 32'h0000_0001, 6'd21);         // tie at the tail
      send_op(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 6'd42);
      send_op(OP_INSERT, '1, 32'h0000_0002, 6'd0);          // tie at the head
      send_op(OP_INSERT, 32'h0000_0001, 32'h5A5A_5A5A, 6'd0);
      send_op(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 6'd7);
      send_op(OP_DELETE, '0, '0, 6'd7);                     // position equals count
      send_op(OP_DELETE, '0, '0, 6'd63);
      send_op(OP_DELETE, '0, '0, 6'd6);                     // last entry
      send_op(OP_DELETE, '1, '1, 6'd0);                     // first entry
      send_op(OP_DELETE, '1, '1, 6'd2);                     // middle, data ignored
      send_op(OP_INSERT, '0, 32'hFFFF_0000, 6'd33);
      send_op(OP_INSERT, 32'hFFFF_FFFE, 32'h0000_FFFF, 6'd12);
      pause_sender();
   endtask

   // fill to capacity against a stalled receiver, refuse while full, then drain
   task automatic test_full_table();
      logic [POS_W-1:0] pos;
      sender_pace = PACE_STEADY;
      hold_asked  <= hold_asked + 1;                        // block backs up on its input
      while (table_fill < DEPTH)
         send_op(OP_INSERT, pick_stamp(), $urandom, POS_W'($urandom_range(63)));
      send_op(OP_INSERT, '0, '1, 6'd0);
      send_op(OP_INSERT, '1, '0, 6'd63);
      send_op(OP_INSERT, pick_stamp(), $urandom, POS_W'($urandom_range(63)));
      sender_pace = PACE_JITTER;
      send_op(OP_DELETE, $urandom, $urandom, 6'd63);        // last slot of a full table
      send_op(OP_INSERT, pick_stamp(), $urandom, POS_W'($urandom_range(63)));
      send_op(OP_INSERT, pick_stamp(), $urandom, POS_W'($urandom_range(63)));
      pause_sender();
      while (table_fill != 0) begin
         if ($urandom_range(9) == 0)
            pos = POS_W'($urandom_range(63));
         else
            pos = POS_W'($urandom_range(table_fill - 1));
         send_op(OP_DELETE, $urandom, $urandom, pos);
      end
      send_op(OP_DELETE, $urandom, $urandom, 6'd0);
      pause_sender();
   endtask

   // mixed traffic; the fill level is steered towards a target that moves
   // between empty, half and full so every occupancy gets exercised
   task automatic test_random_traffic(input int item_total);
      int n;
      int target;
      int roll;
      logic [POS_W-1:0] pos;
      target = DEPTH / 2;
      for (n = 0; n < item_total; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(3))
               0: target = 2;
               1: target = DEPTH / 2;
               2: target = DEPTH - 2;
               default: target = DEPTH + 4;
            endcase
            sender_pace = ($urandom_range(3) == 0) ? PACE_STEADY : PACE_JITTER;
            sink_pace   <= ($urandom_range(3) == 0) ? PACE_STEADY : PACE_JITTER;
         end
         if (n == item_total / 3)
            hold_asked <= hold_asked + 1;
         if (n % 400 == 399)
            pause_sender();
         roll = $urandom_range(99);
         if ((table_fill < target) ? (roll < 75) : (roll < 25)) begin
            send_op(OP_INSERT, pick_stamp(), $urandom, POS_W'($urandom_range(63)));
         end else begin
            roll = $urandom_range(99);
            if (table_fill == 0 || roll < 12)
               pos = POS_W'($urandom_range(63));
            else if (roll < 22)
               pos = '0;
            else if (roll < 32)
               pos = POS_W'(table_fill - 1);
            else
               pos = POS_W'($urandom_range(table_fill - 1));
            send_op(OP_DELETE, $urandom, $urandom, pos);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random_traffic(RANDOM_ITEMS);
      pause_sender();
      repeat (SETTLE) @(posedge clock);
      $display("sent %0d transactions, checked %0d responses in %0d cycles",
               items_sent, outcomes_seen, cycle_count);
      $display("inserts %0d, deletes %0d, refused full %0d, refused position %0d",
               inserts_placed, deletes_done, full_refusals, range_refusals);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("PASS time_sorted_record_table_core");
      end else begin
         $display("%0d mismatches, %0d responses missing", error_count,
                  pending_outcomes.size());
         $display("FAIL time_sorted_record_table_core");
      end
      $finish;
   end

endmodule

// ===== time_sorted_record_table_core.f =====
hdl/tsrt_pkg.sv
hdl/time_sorted_record_table_core.sv
tb/time_sorted_record_table_core_tb.sv
